@@ src/nlcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcf_pkg
// Shared types and constants of the night light mode and color fader.
// ----------------------------------------------------------------------------
package nlcf_pkg;

    // operating modes, encoded as reported on the result channel
    typedef enum logic [1:0] {
        MODE_STARTUP    = 2'd0,
        MODE_WHITE_ON   = 2'd1,
        MODE_OUTAGE     = 2'd2,
        MODE_RAINBOW_ON = 2'd3
    } mode_t;

    // controller sequence
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_PREP,
        CS_MUL,
        CS_DIV,
        CS_COMMIT
    } ctrl_state_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SENSE_THRESHOLD   = 2'd0,
        CFG_TRANSITION_FRAMES = 2'd1,
        CFG_WHITE_GREEN_LEVEL = 2'd2,
        CFG_WHITE_BLUE_LEVEL  = 2'd3
    } cfg_index_t;

    // fixed field widths
    localparam int THR_W       = 10;
    localparam int FRAMES_W    = 16;
    localparam int LEVEL_W     = 8;
    localparam int PWM_W       = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // configuration reset values
    localparam logic [THR_W-1:0]    THR_RESET    = 10'd512;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 16'd187;
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 8'd100;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic div_start;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_div;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/nlcf_div_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcf_div_lane
// Restoring divider, one quotient bit per step, for one color channel.
// ----------------------------------------------------------------------------
module nlcf_div_lane #(
    parameter int Q_W = 8,
    parameter int D_W = 16
) (
    input  logic               aclk,
    input  logic               start,
    input  logic               step,
    input  logic [Q_W+D_W-1:0] dividend,
    input  logic [D_W-1:0]     divisor,
    output logic [Q_W-1:0]     quotient
);

    logic [D_W-1:0] rem_reg;
    logic [Q_W-1:0] low_reg;
    logic [D_W:0]   trial;
    logic           fits;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, low_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    // upper dividend bits start the remainder, quotient bits fill in from below
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[Q_W+D_W-1:Q_W];
            low_reg <= dividend[Q_W-1:0];
        end else if (step) begin
            rem_reg <= fits ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], fits};
        end
    end

    assign quotient = low_reg;

endmodule

@@ src/nlcf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcf_datapath
// Mode state, fade state, configuration, dividers and the result register.
// ----------------------------------------------------------------------------
module nlcf_datapath #(
    parameter int SAMPLE_BITS = 10,
    parameter int COLOR_BITS  = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  nlcf_pkg::dp_cmd_t                     cmd,
    output nlcf_pkg::dp_status_t                  status,
    input  logic                                  cfg_wr_en,
    input  logic [nlcf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [nlcf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]                s_sense_sample,
    input  logic [COLOR_BITS-1:0]                 s_cand_red,
    input  logic [COLOR_BITS-1:0]                 s_cand_green,
    input  logic [COLOR_BITS-1:0]                 s_cand_blue,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_mode,
    output logic                                  m_rail_enable,
    output logic                                  m_leds_off,
    output logic [nlcf_pkg::PWM_W-1:0]            m_pwm_red,
    output logic [nlcf_pkg::PWM_W-1:0]            m_pwm_green,
    output logic [nlcf_pkg::PWM_W-1:0]            m_pwm_blue,
    output logic                                  m_indicator_led,
    output logic                                  m_long_sleep,
    output logic                                  m_candidate_retry
);
    import nlcf_pkg::*;

    localparam int CW        = COLOR_BITS;
    localparam int TW        = CW + 3;
    localparam int CMP_W     = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int PWM_EXT_W = (CW > PWM_W) ? CW : PWM_W;
    localparam int LVL_EXT_W = (CW > LEVEL_W) ? CW : LEVEL_W;
    localparam int PROD_W    = CW + FRAMES_W;
    localparam logic [CW-1:0] CMAX = '1;
    localparam logic [CW-1:0] HALF = CMAX >> 1;

    // configuration registers
    logic [THR_W-1:0]    thr_reg;
    logic [FRAMES_W-1:0] tf_reg;
    logic [LEVEL_W-1:0]  wg_reg;
    logic [LEVEL_W-1:0]  wb_reg;

    // latched transaction
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic [CW-1:0]          cand_reg [3];

    // block state
    mode_t               mode_reg, mode_next;
    mode_t               last_reg, last_next;
    logic [FRAMES_W-1:0] frame_reg, frame_next;
    logic                restart_reg, restart_next;
    logic [CW-1:0]       from_reg [3];
    logic [CW-1:0]       from_next [3];
    logic [CW-1:0]       to_reg [3];
    logic [CW-1:0]       to_next [3];
    logic [CW-1:0]       drive_reg [3];
    logic [CW-1:0]       drive_next [3];
    logic                rail_reg, rail_next;
    logic                off_reg, off_next;
    logic                blink_reg, blink_next;

    // per-tick working registers
    logic                seg_reg;
    logic                retry_reg;
    logic [CW-1:0]       efrom_reg [3];
    logic [CW-1:0]       eto_reg [3];
    logic [CW-1:0]       diff_reg [3];
    logic                up_reg [3];
    logic [FRAMES_W-1:0] eframe_reg;

    // result register
    logic       out_valid_reg;
    logic [1:0] out_mode_reg;
    logic       out_rail_reg;
    logic       out_off_reg;
    logic [PWM_W-1:0] out_pwm_reg [3];
    logic       out_ind_reg;
    logic       out_lsleep_reg;
    logic       out_retry_reg;

    logic                present;
    logic                seg_start;
    logic                cand_ok;
    logic                retry_now;
    logic [TW-1:0]       total;
    logic                spread_ok;
    logic [CW-1:0]       efrom [3];
    logic [CW-1:0]       eto [3];
    logic [PROD_W-1:0]   prod [3];
    logic [CW-1:0]       quot [3];
    logic [CW-1:0]       cur [3];
    logic                ind;
    logic                lsleep;
    logic                lost;
    logic [LVL_EXT_W-1:0] wg_ext;
    logic [LVL_EXT_W-1:0] wb_ext;
    logic [PWM_EXT_W-1:0] drive_ext [3];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            tf_reg  <= FRAMES_RESET;
            wg_reg  <= LEVEL_RESET;
            wb_reg  <= LEVEL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SENSE_THRESHOLD:   thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_TRANSITION_FRAMES: tf_reg  <= cfg_wdata[FRAMES_W-1:0];
                CFG_WHITE_GREEN_LEVEL: wg_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_WHITE_BLUE_LEVEL:  wb_reg  <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            samp_reg    <= s_sense_sample;
            cand_reg[0] <= s_cand_red;
            cand_reg[1] <= s_cand_green;
            cand_reg[2] <= s_cand_blue;
        end
    end

    // supply check
    assign present = CMP_W'(samp_reg) >= CMP_W'(thr_reg);

    // candidate test: total in range and one channel far from the mean,
    // with floor(T/3) compares rewritten as compares against 3*k
    always_comb begin
        logic [TW-1:0] k_hi;
        logic [TW-1:0] k_lo;
        total = TW'(cand_reg[0]) + TW'(cand_reg[1]) + TW'(cand_reg[2]);
        spread_ok = 1'b0;
        for (int i = 0; i < 3; i++) begin
            k_hi = TW'(cand_reg[i]) + TW'(HALF) + TW'(1);
            k_lo = TW'(cand_reg[i]) - TW'(HALF);
            if (total >= ((k_hi << 1) + k_hi))
                spread_ok = 1'b1;
            if ((cand_reg[i] > HALF) && (total < ((k_lo << 1) + k_lo)))
                spread_ok = 1'b1;
        end
        cand_ok = (total > TW'(CMAX)) && (total <= (TW'(CMAX) << 1)) && spread_ok;
    end

    // segment decision and effective endpoints for this tick
    assign seg_start = restart_reg || (frame_reg >= tf_reg);
    assign retry_now = (mode_reg == MODE_RAINBOW_ON) && seg_start && !cand_ok;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            efrom[i] = seg_start ? to_reg[i] : from_reg[i];
            eto[i]   = seg_start ? cand_reg[i] : to_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            seg_reg    <= seg_start;
            retry_reg  <= retry_now;
            eframe_reg <= seg_start ? '0 : frame_reg;
            for (int i = 0; i < 3; i++) begin
                efrom_reg[i] <= efrom[i];
                eto_reg[i]   <= eto[i];
                up_reg[i]    <= eto[i] >= efrom[i];
                diff_reg[i]  <= (eto[i] >= efrom[i]) ? eto[i] - efrom[i]
                                                     : efrom[i] - eto[i];
            end
        end
    end

    // one divider lane per channel: (diff * frame) / transition_frames
    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign prod[g] = PROD_W'(diff_reg[g]) * PROD_W'(eframe_reg);

        nlcf_div_lane #(
            .Q_W (CW),
            .D_W (FRAMES_W)
        ) u_lane (
            .aclk     (aclk),
            .start    (cmd.div_start),
            .step     (cmd.div_step),
            .dividend (prod[g]),
            .divisor  (tf_reg),
            .quotient (quot[g])
        );
    end

    // interpolated color, zero step when transition_frames is zero
    always_comb begin
        logic [CW-1:0] stp;
        for (int i = 0; i < 3; i++) begin
            stp    = (tf_reg == '0) ? '0 : quot[i];
            cur[i] = up_reg[i] ? efrom_reg[i] + stp : efrom_reg[i] - stp;
        end
    end

    assign wg_ext = LVL_EXT_W'(wg_reg);
    assign wb_ext = LVL_EXT_W'(wb_reg);

    // next state of the tick
    always_comb begin
        mode_next    = mode_reg;
        last_next    = last_reg;
        frame_next   = frame_reg;
        restart_next = restart_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        drive_next   = drive_reg;
        rail_next    = rail_reg;
        off_next     = off_reg;
        blink_next   = blink_reg;
        ind          = 1'b0;
        lsleep       = 1'b0;
        lost         = 1'b0;
        case (mode_reg)
            MODE_STARTUP: begin
                rail_next     = 1'b1;
                off_next      = 1'b0;
                drive_next[0] = '0;
                drive_next[1] = wg_ext[CW-1:0];
                drive_next[2] = wb_ext[CW-1:0];
                mode_next     = MODE_WHITE_ON;
                last_next     = MODE_WHITE_ON;
            end
            MODE_WHITE_ON: begin
                lost = !present;
            end
            MODE_OUTAGE: begin
                ind        = blink_reg;
                lsleep     = !blink_reg;
                blink_next = !blink_reg;
                if (present) begin
                    rail_next = 1'b1;
                    if (last_reg == MODE_WHITE_ON) begin
                        mode_next = MODE_RAINBOW_ON;
                        last_next = MODE_RAINBOW_ON;
                    end else begin
                        mode_next = MODE_STARTUP;
                    end
                end
            end
            MODE_RAINBOW_ON: begin
                if (!retry_reg) begin
                    if (seg_reg) begin
                        restart_next = 1'b0;
                        from_next    = efrom_reg;
                        to_next      = eto_reg;
                    end
                    for (int i = 0; i < 3; i++)
                        drive_next[i] = CMAX - cur[i];
                    off_next   = 1'b0;
                    frame_next = eframe_reg + 1'b1;
                    lost       = !present;
                end
            end
            default: ;
        endcase
        // supply dropout forces everything off
        if (lost) begin
            rail_next    = 1'b0;
            off_next     = 1'b1;
            mode_next    = MODE_OUTAGE;
            restart_next = 1'b1;
            for (int i = 0; i < 3; i++) begin
                to_next[i]    = '0;
                drive_next[i] = '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++)
            drive_ext[i] = PWM_EXT_W'(drive_next[i]);
    end

    // state update at commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_STARTUP;
            last_reg    <= MODE_STARTUP;
            frame_reg   <= '0;
            restart_reg <= 1'b1;
            rail_reg    <= 1'b0;
            off_reg     <= 1'b1;
            blink_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                from_reg[i]  <= '0;
                to_reg[i]    <= '0;
                drive_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            mode_reg    <= mode_next;
            last_reg    <= last_next;
            frame_reg   <= frame_next;
            restart_reg <= restart_next;
            rail_reg    <= rail_next;
            off_reg     <= off_next;
            blink_reg   <= blink_next;
            from_reg    <= from_next;
            to_reg      <= to_next;
            drive_reg   <= drive_next;
        end
    end

    // result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_mode_reg   <= mode_next;
            out_rail_reg   <= rail_next;
            out_off_reg    <= off_next;
            out_ind_reg    <= ind;
            out_lsleep_reg <= lsleep;
            out_retry_reg  <= retry_reg && (mode_reg == MODE_RAINBOW_ON);
            for (int i = 0; i < 3; i++)
                out_pwm_reg[i] <= off_next ? '0 : drive_ext[i][PWM_W-1:0];
        end
    end

    assign status.need_div = (mode_reg == MODE_RAINBOW_ON) && !retry_now;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid           = out_valid_reg;
    assign m_mode            = out_mode_reg;
    assign m_rail_enable     = out_rail_reg;
    assign m_leds_off        = out_off_reg;
    assign m_pwm_red         = out_pwm_reg[0];
    assign m_pwm_green       = out_pwm_reg[1];
    assign m_pwm_blue        = out_pwm_reg[2];
    assign m_indicator_led   = out_ind_reg;
    assign m_long_sleep      = out_lsleep_reg;
    assign m_candidate_retry = out_retry_reg;

endmodule

@@ src/nlcf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcf_ctrl
// Sequencer: capture, prepare, multiply, divide steps and commit.
// ----------------------------------------------------------------------------
module nlcf_ctrl #(
    parameter int COLOR_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  nlcf_pkg::dp_status_t status,
    output nlcf_pkg::dp_cmd_t    cmd
);
    import nlcf_pkg::*;

    localparam int CNT_W = $clog2(COLOR_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COLOR_BITS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_PREP;
                end
            end
            CS_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.need_div ? CS_MUL : CS_COMMIT;
            end
            CS_MUL: begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = CS_DIV;
            end
            CS_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = CS_COMMIT;
            end
            CS_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

endmodule

@@ src/night_light_mode_and_color_fader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// night_light_mode_and_color_fader
// Night light mode sequencer with rainbow crossfade and inverted PWM levels.
// ----------------------------------------------------------------------------
// Usage:
//   One s_ transaction is one tick: a supply sense sample and a random
//   candidate color. Each tick yields exactly one m_ transaction with the
//   mode after the tick, rail and off levels, three PWM duty values, the
//   blink indicator, the sleep request and the candidate retry flag.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata);
//   write it only while no tick is in flight. The block does not check it.
// Sequence:
//   A rainbow tick that is not a retry runs its crossfade division in three
//   parallel restoring dividers, one quotient bit per cycle, through the
//   states IDLE, PREP, MUL, DIV and COMMIT. All other ticks go from PREP
//   straight to COMMIT. s_ready is high only while no tick is in flight, so
//   a new tick is accepted only after the last one has committed.
// Stalls:
//   A finished result waits in the output register; a new tick is accepted
//   meanwhile, and its commit waits until that register is free.
// Reset:
//   aresetn (synchronous, active low) restores the configuration values and
//   the startup mode with the outputs off; no result is pending afterwards.
// ----------------------------------------------------------------------------
module night_light_mode_and_color_fader #(
    parameter int SAMPLE_BITS = 10,
    parameter int COLOR_BITS  = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [nlcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nlcf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [SAMPLE_BITS-1:0]           s_sense_sample,
    input  logic [COLOR_BITS-1:0]            s_cand_red,
    input  logic [COLOR_BITS-1:0]            s_cand_green,
    input  logic [COLOR_BITS-1:0]            s_cand_blue,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_mode,
    output logic                             m_rail_enable,
    output logic                             m_leds_off,
    output logic [nlcf_pkg::PWM_W-1:0]       m_pwm_red,
    output logic [nlcf_pkg::PWM_W-1:0]       m_pwm_green,
    output logic [nlcf_pkg::PWM_W-1:0]       m_pwm_blue,
    output logic                             m_indicator_led,
    output logic                             m_long_sleep,
    output logic                             m_candidate_retry
);
    import nlcf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    nlcf_ctrl #(
        .COLOR_BITS (COLOR_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // state, arithmetic and result register
    nlcf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COLOR_BITS  (COLOR_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_sense_sample    (s_sense_sample),
        .s_cand_red        (s_cand_red),
        .s_cand_green      (s_cand_green),
        .s_cand_blue       (s_cand_blue),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mode            (m_mode),
        .m_rail_enable     (m_rail_enable),
        .m_leds_off        (m_leds_off),
        .m_pwm_red         (m_pwm_red),
        .m_pwm_green       (m_pwm_green),
        .m_pwm_blue        (m_pwm_blue),
        .m_indicator_led   (m_indicator_led),
        .m_long_sleep      (m_long_sleep),
        .m_candidate_retry (m_candidate_retry)
    );

endmodule

@@ src/nlcf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcf_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nlcf_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_mode,
    input logic                       m_rail_enable,
    input logic                       m_leds_off,
    input logic [nlcf_pkg::PWM_W-1:0] m_pwm_red,
    input logic [nlcf_pkg::PWM_W-1:0] m_pwm_green,
    input logic [nlcf_pkg::PWM_W-1:0] m_pwm_blue,
    input logic                       m_indicator_led,
    input logic                       m_long_sleep,
    input logic                       m_candidate_retry
);
    import nlcf_pkg::*;

    // a stalled transaction holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mode) && $stable(m_pwm_red)
            && $stable(m_pwm_green) && $stable(m_pwm_blue) && $stable(m_leds_off))
        else $error("result changed while stalled");

    // forced off means zero duty on every channel
    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_leds_off |->
            m_pwm_red == '0 && m_pwm_green == '0 && m_pwm_blue == '0)
        else $error("pwm active while leds off");

    // indicator and sleep request come from outage ticks: outputs off, never both
    a_blink_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_indicator_led || m_long_sleep) |->
            m_leds_off && !(m_indicator_led && m_long_sleep))
        else $error("indicator or sleep with leds on");

    // a retry only happens in rainbow mode
    a_retry_rainbow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_candidate_retry |-> m_mode == MODE_RAINBOW_ON)
        else $error("retry outside rainbow mode");

    // rail off always comes with outputs off
    a_rail_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rail_enable |-> m_leds_off)
        else $error("leds on with rail disabled");

endmodule

bind night_light_mode_and_color_fader nlcf_checker u_nlcf_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_mode            (m_mode),
    .m_rail_enable     (m_rail_enable),
    .m_leds_off        (m_leds_off),
    .m_pwm_red         (m_pwm_red),
    .m_pwm_green       (m_pwm_green),
    .m_pwm_blue        (m_pwm_blue),
    .m_indicator_led   (m_indicator_led),
    .m_long_sleep      (m_long_sleep),
    .m_candidate_retry (m_candidate_retry)
);

@@ test/tb_night_light_mode_and_color_fader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_night_light_mode_and_color_fader
// Self-checking bench for the night light mode sequencer and color fader.
// Ticks enter on the s_ channel after random gaps. Results leave on the m_
// channel under random stalls. A behavioral model of the mode sequence, the
// candidate color test and the truncating crossfade predicts every result
// field. Directed ticks cover the mode cycle, the candidate limits and the
// register extremes. Random phases then run under several register settings.
// ----------------------------------------------------------------------------
module tb_night_light_mode_and_color_fader;
    import nlcf_pkg::*;

    localparam int         SAMPLE_BITS = 10;
    localparam int         COLOR_BITS  = 8;
    localparam logic [7:0] CMAX        = 8'hFF;
    localparam int         CYCLE_LIMIT = 200000;

    // one result transaction
    typedef struct packed {
        mode_t      mode;
        logic       rail;
        logic       off;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       ind;
        logic       lsleep;
        logic       retry;
    } fader_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    cfg_index_t              cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [SAMPLE_BITS-1:0]  s_sense_sample;
    logic [COLOR_BITS-1:0]   s_cand_red;
    logic [COLOR_BITS-1:0]   s_cand_green;
    logic [COLOR_BITS-1:0]   s_cand_blue;
    logic                    m_valid;
    logic                    m_ready;
    logic [1:0]              m_mode;
    logic                    m_rail_enable;
    logic                    m_leds_off;
    logic [PWM_W-1:0]        m_pwm_red;
    logic [PWM_W-1:0]        m_pwm_green;
    logic [PWM_W-1:0]        m_pwm_blue;
    logic                    m_indicator_led;
    logic                    m_long_sleep;
    logic                    m_candidate_retry;

    // expected results, oldest first
    fader_result_t pending_outputs[$];
    int            err_count   = 0;
    int            cycle_count = 0;
    logic          no_idle     = 1'b0;

    // model copy of the registers
    logic [9:0]  thr_cfg;
    logic [15:0] frames_cfg;
    logic [7:0]  green_cfg;
    logic [7:0]  blue_cfg;

    // model copy of the state
    mode_t       nl_mode;
    mode_t       nl_last_shown;
    logic [15:0] nl_frame;
    logic        nl_restart;
    logic [7:0]  nl_from [3];
    logic [7:0]  nl_to [3];
    logic [7:0]  nl_drive [3];
    logic        nl_rail;
    logic        nl_off;
    logic        nl_blink;

    night_light_mode_and_color_fader #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sense_sample   (s_sense_sample),
        .s_cand_red       (s_cand_red),
        .s_cand_green     (s_cand_green),
        .s_cand_blue      (s_cand_blue),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mode           (m_mode),
        .m_rail_enable    (m_rail_enable),
        .m_leds_off       (m_leds_off),
        .m_pwm_red        (m_pwm_red),
        .m_pwm_green      (m_pwm_green),
        .m_pwm_blue       (m_pwm_blue),
        .m_indicator_led  (m_indicator_led),
        .m_long_sleep     (m_long_sleep),
        .m_candidate_retry(m_candidate_retry)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    task automatic reset_model();
        thr_cfg       = THR_RESET;
        frames_cfg    = FRAMES_RESET;
        green_cfg     = LEVEL_RESET;
        blue_cfg      = LEVEL_RESET;
        nl_mode       = MODE_STARTUP;
        nl_last_shown = MODE_STARTUP;
        nl_frame      = '0;
        nl_restart    = 1'b1;
        for (int i = 0; i < 3; i++) begin
            nl_from[i]  = '0;
            nl_to[i]    = '0;
            nl_drive[i] = '0;
        end
        nl_rail  = 1'b0;
        nl_off   = 1'b1;
        nl_blink = 1'b0;
    endtask

    // total between one and two full scales, and one channel far from the mean
    function automatic logic cand_passes(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned total;
        int unsigned avg;
        int unsigned chan [3];
        int unsigned spread;
        chan  = '{r, g, b};
        total = chan[0] + chan[1] + chan[2];
        if (total <= CMAX || total > 2 * CMAX)
            return 1'b0;
        avg = total / 3;
        for (int i = 0; i < 3; i++) begin
            spread = (avg >= chan[i]) ? avg - chan[i] : chan[i] - avg;
            if (spread > CMAX / 2)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // supply check: a low sample shuts everything off
    function automatic void drop_supply(logic [9:0] sample);
        if (sample < thr_cfg) begin
            nl_rail    = 1'b0;
            nl_off     = 1'b1;
            nl_mode    = MODE_OUTAGE;
            nl_restart = 1'b1;
            for (int i = 0; i < 3; i++) begin
                nl_to[i]    = '0;
                nl_drive[i] = '0;
            end
        end
    endfunction

    // one tick of the sequencer and fader, returns the result it produces
    function automatic fader_result_t next_fader_outputs(logic [9:0] sample, logic [7:0] r,
                                                         logic [7:0] g, logic [7:0] b);
        fader_result_t res;
        logic [7:0]    cand [3];
        logic          new_seg;
        logic          retry;
        logic          ind;
        logic          lsleep;
        int unsigned   diff;
        int unsigned   step;
        logic [7:0]    cur;
        cand   = '{r, g, b};
        retry  = 1'b0;
        ind    = 1'b0;
        lsleep = 1'b0;
        case (nl_mode)
            MODE_STARTUP: begin
                nl_rail       = 1'b1;
                nl_off        = 1'b0;
                nl_drive[0]   = '0;
                nl_drive[1]   = green_cfg;
                nl_drive[2]   = blue_cfg;
                nl_mode       = MODE_WHITE_ON;
                nl_last_shown = MODE_WHITE_ON;
            end
            MODE_WHITE_ON: begin
                drop_supply(sample);
            end
            MODE_OUTAGE: begin
                ind      = nl_blink;
                lsleep   = !nl_blink;
                nl_blink = !nl_blink;
                if (sample >= thr_cfg) begin
                    nl_rail = 1'b1;
                    if (nl_last_shown == MODE_WHITE_ON) begin
                        nl_mode       = MODE_RAINBOW_ON;
                        nl_last_shown = MODE_RAINBOW_ON;
                    end else begin
                        nl_mode = MODE_STARTUP;
                    end
                end
            end
            default: begin
                new_seg = nl_restart || (nl_frame >= frames_cfg);
                if (new_seg && !cand_passes(r, g, b)) begin
                    // rejected candidate: nothing changes, no supply check
                    retry = 1'b1;
                end else begin
                    if (new_seg) begin
                        nl_frame   = '0;
                        nl_restart = 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            nl_from[i] = nl_to[i];
                            nl_to[i]   = cand[i];
                        end
                    end
                    // truncating linear crossfade, inverted drive
                    for (int i = 0; i < 3; i++) begin
                        diff = (nl_to[i] >= nl_from[i]) ? nl_to[i] - nl_from[i]
                                                         : nl_from[i] - nl_to[i];
                        step = (frames_cfg == 0) ? 0 : (diff * nl_frame) / frames_cfg;
                        cur  = (nl_to[i] >= nl_from[i]) ? 8'(nl_from[i] + step)
                                                         : 8'(nl_from[i] - step);
                        nl_drive[i] = CMAX - cur;
                    end
                    nl_off   = 1'b0;
                    nl_frame = nl_frame + 16'd1;
                    drop_supply(sample);
                end
            end
        endcase
        res.mode   = nl_mode;
        res.rail   = nl_rail;
        res.off    = nl_off;
        res.red    = nl_off ? 8'd0 : nl_drive[0];
        res.green  = nl_off ? 8'd0 : nl_drive[1];
        res.blue   = nl_off ? 8'd0 : nl_drive[2];
        res.ind    = ind;
        res.lsleep = lsleep;
        res.retry  = retry;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write; the caller lowers the write enable after the last
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_SENSE_THRESHOLD:   thr_cfg    = val[9:0];
            CFG_TRANSITION_FRAMES: frames_cfg = val;
            CFG_WHITE_GREEN_LEVEL: green_cfg  = val[7:0];
            CFG_WHITE_BLUE_LEVEL:  blue_cfg   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [9:0] thr, logic [15:0] frames,
                                logic [7:0] green, logic [7:0] blue);
        write_reg(CFG_SENSE_THRESHOLD, {6'd0, thr});
        write_reg(CFG_TRANSITION_FRAMES, frames);
        write_reg(CFG_WHITE_GREEN_LEVEL, {8'd0, green});
        write_reg(CFG_WHITE_BLUE_LEVEL, {8'd0, blue});
        cfg_wr_en <= 1'b0;
    endtask

    // send one tick transaction and record what it should produce
    task automatic send_tick(logic [9:0] sample, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sense_sample <= sample;
        s_cand_red     <= r;
        s_cand_green   <= g;
        s_cand_blue    <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_outputs.push_back(next_fader_outputs(sample, r, g, b));
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // mostly well-formed candidates, some plain noise
    function automatic void pick_candidate(output logic [7:0] r, output logic [7:0] g,
                                           output logic [7:0] b);
        logic noise;
        noise = ($urandom_range(0, 3) == 0);
        do begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
        end while (!noise && !cand_passes(r, g, b));
    endfunction

    // mostly supply present, now and then a dropout
    function automatic logic [9:0] pick_sample();
        if (thr_cfg != 0 && $urandom_range(0, 7) == 0)
            return 10'($urandom_range(0, thr_cfg - 1));
        return 10'($urandom_range(thr_cfg, 1023));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // full mode cycle with candidate limits and a short crossfade
    task automatic test_mode_cycle();
        wait_idle();
        program_regs(10'd512, 16'd3, 8'd100, 8'd100);
        send_tick(10'd0, 8'd0, 8'd0, 8'd0);          // startup to white
        send_tick(10'd1023, 8'd255, 8'd255, 8'd255); // white holds
        send_tick(10'd511, 8'd0, 8'd0, 8'd0);        // just below threshold
        send_tick(10'd0, 8'd0, 8'd0, 8'd0);          // still gone, blink
        send_tick(10'd512, 8'd0, 8'd0, 8'd0);        // back after white: rainbow
        send_tick(10'd0, 8'd255, 8'd0, 8'd0);        // total one scale: retry, low sample ignored
        send_tick(10'd512, 8'd255, 8'd255, 8'd1);    // total above two scales: retry
        send_tick(10'd512, 8'd1, 8'd191, 8'd192);    // spread just too small: retry
        send_tick(10'd1023, 8'd255, 8'd1, 8'd0);     // smallest passing total
        send_tick(10'd700, 8'd255, 8'd255, 8'd255);  // mid segment
        send_tick(10'd700, 8'd0, 8'd0, 8'd0);
        send_tick(10'd700, 8'd255, 8'd255, 8'd0);    // new segment, largest total
        send_tick(10'd700, 8'd0, 8'd192, 8'd192);
        send_tick(10'd511, 8'd0, 8'd0, 8'd0);        // dropout during rainbow
        send_tick(10'd600, 8'd0, 8'd0, 8'd0);        // back after rainbow: startup
        send_tick(10'd0, 8'd0, 8'd0, 8'd0);          // to white again
    endtask

    // highest threshold, zero frames, full and empty white levels
    task automatic test_register_extremes();
        wait_idle();
        program_regs(10'd1023, 16'd0, 8'd255, 8'd0);
        send_tick(10'd1022, 8'd0, 8'd0, 8'd0);
        send_tick(10'd1023, 8'd0, 8'd192, 8'd192);
        send_tick(10'd1023, 8'd0, 8'd192, 8'd192);   // every tick starts a segment
        send_tick(10'd1023, 8'd255, 8'd1, 8'd0);
        send_tick(10'd0, 8'd255, 8'd255, 8'd0);
        send_tick(10'd1023, 8'd0, 8'd0, 8'd0);
        send_tick(10'd1023, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic run_random_phase(logic [9:0] thr, logic [15:0] frames, logic [7:0] green,
                                    logic [7:0] blue, int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        wait_idle();
        program_regs(thr, frames, green, blue);
        for (int i = 0; i < count; i++) begin
            // a stretch at full rate on both sides
            no_idle = (i >= 20 && i < 35);
            pick_candidate(r, g, b);
            send_tick(pick_sample(), r, g, b);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        run_random_phase(10'd512, 16'd5, 8'd100, 8'd100, 90);
        run_random_phase(10'd0, 16'd65535, 8'd255, 8'd255, 30);
        run_random_phase(10'd300, 16'd1, 8'd0, 8'd200, 90);
        run_random_phase(10'd1023, 16'd8, 8'd255, 8'd0, 60);
        run_random_phase(10'd700, 16'd3, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 120);
        run_random_phase(THR_RESET, FRAMES_RESET, LEVEL_RESET, LEVEL_RESET, 60);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial begin
        fader_result_t want;
        int            stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_outputs.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result transaction, expected none, actual mode %0d",
                         $time, m_mode);
            end else begin
                want = pending_outputs.pop_front();
                check_field("mode", want.mode, m_mode);
                check_field("rail_enable", want.rail, m_rail_enable);
                check_field("leds_off", want.off, m_leds_off);
                check_field("pwm_red", want.red, m_pwm_red);
                check_field("pwm_green", want.green, m_pwm_green);
                check_field("pwm_blue", want.blue, m_pwm_blue);
                check_field("indicator_led", want.ind, m_indicator_led);
                check_field("long_sleep", want.lsleep, m_long_sleep);
                check_field("candidate_retry", want.retry, m_candidate_retry);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_SENSE_THRESHOLD;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_sense_sample <= '0;
        s_cand_red     <= '0;
        s_cand_green   <= '0;
        s_cand_blue    <= '0;
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mode_cycle();
        test_register_extremes();
        test_random_phases();
        wait_idle();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
src/nlcf_pkg.sv
src/nlcf_div_lane.sv
src/nlcf_datapath.sv
src/nlcf_ctrl.sv
src/night_light_mode_and_color_fader.sv
src/nlcf_checker.sv
test/tb_night_light_mode_and_color_fader.sv
